// ===== rtl/mdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply/divide unit package
// Shared widths, register offsets, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mdu_pkg;

    localparam int OFFSET_W   = 4;
    localparam int BYTE_W     = 8;
    localparam int DIVIDEND_W = 32;
    localparam int HALF_W     = 16;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int COUNT_W    = $clog2(DIV_STEPS);

    // bus access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register byte offsets
    localparam logic [OFFSET_W-1:0] OFF_DIVIDEND_B0 = 4'd0;
    localparam logic [OFFSET_W-1:0] OFF_DIVIDEND_B1 = 4'd1;
    localparam logic [OFFSET_W-1:0] OFF_DIVIDEND_B2 = 4'd2;
    localparam logic [OFFSET_W-1:0] OFF_DIVIDEND_B3 = 4'd3;
    localparam logic [OFFSET_W-1:0] OFF_MULT_LO     = 4'd4;
    localparam logic [OFFSET_W-1:0] OFF_MULT_HI     = 4'd5;
    localparam logic [OFFSET_W-1:0] OFF_DIVISOR_LO  = 4'd6;
    localparam logic [OFFSET_W-1:0] OFF_DIVISOR_HI  = 4'd7;
    localparam logic [OFFSET_W-1:0] OFF_RESULT_B0   = 4'd8;
    localparam logic [OFFSET_W-1:0] OFF_RESULT_B1   = 4'd9;
    localparam logic [OFFSET_W-1:0] OFF_RESULT_B2   = 4'd10;
    localparam logic [OFFSET_W-1:0] OFF_RESULT_B3   = 4'd11;
    localparam logic [OFFSET_W-1:0] OFF_REMAIN_LO   = 4'd12;
    localparam logic [OFFSET_W-1:0] OFF_REMAIN_HI   = 4'd13;
    localparam logic [OFFSET_W-1:0] OFF_SIGN_MODE   = 4'd14;
    localparam logic [OFFSET_W-1:0] OFF_STATUS      = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_FIX,
        ST_RESP
    } mdu_state_t;

    typedef struct packed {
        logic access;    // perform the register access of the incoming item
        logic mul_exec;  // write the product into the result
        logic div_init;  // load magnitudes, or finish a divide by zero
        logic div_step;  // one restoring divide step
        logic div_fix;   // apply signs and write quotient and remainder
    } mdu_cmd_t;

    typedef struct packed {
        logic mul_go;    // incoming item writes the multiplier high byte
        logic div_go;    // incoming item writes the divisor high byte
        logic div_zero;  // divisor is zero
        logic div_last;  // final divide step this cycle
    } mdu_status_t;

endpackage
`default_nettype wire

// ===== rtl/mdu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply/divide unit controller
// Sequences one item at a time: access, optional multiply or divide, reply.
// ----------------------------------------------------------------------------
module mdu_ctrl
    import mdu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire mdu_status_t status,
    output mdu_cmd_t         ctrl
);

    mdu_state_t state_reg;
    mdu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.access = in_valid;
                if (in_valid)
                begin
                    priority if (status.mul_go)
                        state_next = ST_MUL;
                    else if (status.div_go)
                        state_next = ST_DIV_INIT;
                    else
                        state_next = ST_RESP;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_exec = 1'b1;
                state_next    = ST_RESP;
            end
            ST_DIV_INIT:
            begin
                ctrl.div_init = 1'b1;
                state_next    = status.div_zero ? ST_RESP : ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                ctrl.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                ctrl.div_fix = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/mdu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply/divide unit datapath
// Register file, 17x17 signed multiplier and a one-bit-per-cycle restoring
// divider working on magnitudes.
// ----------------------------------------------------------------------------
module mdu_datapath
    import mdu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mdu_cmd_t            ctrl,
    input  wire logic                in_cmd,
    input  wire logic [OFFSET_W-1:0] in_offset,
    input  wire logic [BYTE_W-1:0]   in_wdata,
    output mdu_status_t              status,
    output logic [BYTE_W-1:0]        read_data
);

    // architectural registers
    logic [DIVIDEND_W-1:0] dividend_reg,   dividend_next;
    logic [HALF_W-1:0]     multiplier_reg, multiplier_next;
    logic [HALF_W-1:0]     divisor_reg,    divisor_next;
    logic [DIVIDEND_W-1:0] result_reg,     result_next;
    logic [HALF_W-1:0]     remainder_reg,  remainder_next;
    logic                  sign_mode_reg,  sign_mode_next;
    logic                  mult_done_reg,  mult_done_next;
    logic [BYTE_W-1:0]     rdata_reg,      rdata_next;

    // divider working registers
    logic [DIVIDEND_W-1:0] quo_reg,   quo_next;
    logic [HALF_W:0]       part_reg,  part_next;
    logic [HALF_W-1:0]     mag_b_reg, mag_b_next;
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic signed [HALF_W:0]     op_a;
    logic signed [HALF_W:0]     op_b;
    logic signed [2*HALF_W+1:0] product;
    logic                       neg_a;
    logic                       neg_b;
    logic [HALF_W:0]            part_shift;
    logic [HALF_W+1:0]          diff;
    logic [BYTE_W-1:0]          read_mux;

    // multiply: the low half of the dividend by the multiplier
    assign op_a    = {sign_mode_reg & dividend_reg[HALF_W-1], dividend_reg[HALF_W-1:0]};
    assign op_b    = {sign_mode_reg & multiplier_reg[HALF_W-1], multiplier_reg};
    assign product = op_a * op_b;

    assign neg_a = sign_mode_reg & dividend_reg[DIVIDEND_W-1];
    assign neg_b = sign_mode_reg & divisor_reg[HALF_W-1];

    assign part_shift = {part_reg[HALF_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign diff       = {1'b0, part_shift} - {2'b00, mag_b_reg};

    assign status.mul_go   = (in_cmd == CMD_WRITE) && (in_offset == OFF_MULT_HI);
    assign status.div_go   = (in_cmd == CMD_WRITE) && (in_offset == OFF_DIVISOR_HI);
    assign status.div_zero = (divisor_reg == '0);
    assign status.div_last = (count_reg == COUNT_W'(DIV_STEPS - 1));

    assign read_data = rdata_reg;

    always_comb
    begin
        unique case (in_offset)
            OFF_DIVIDEND_B0: read_mux = dividend_reg[7:0];
            OFF_DIVIDEND_B1: read_mux = dividend_reg[15:8];
            OFF_DIVIDEND_B2: read_mux = dividend_reg[23:16];
            OFF_DIVIDEND_B3: read_mux = dividend_reg[31:24];
            OFF_MULT_LO:     read_mux = multiplier_reg[7:0];
            OFF_MULT_HI:     read_mux = multiplier_reg[15:8];
            OFF_DIVISOR_LO:  read_mux = divisor_reg[7:0];
            OFF_DIVISOR_HI:  read_mux = divisor_reg[15:8];
            OFF_RESULT_B0:   read_mux = result_reg[7:0];
            OFF_RESULT_B1:   read_mux = result_reg[15:8];
            OFF_RESULT_B2:   read_mux = result_reg[23:16];
            OFF_RESULT_B3:   read_mux = result_reg[31:24];
            OFF_REMAIN_LO:   read_mux = remainder_reg[7:0];
            OFF_REMAIN_HI:   read_mux = remainder_reg[15:8];
            OFF_SIGN_MODE:   read_mux = {{(BYTE_W-1){1'b0}}, sign_mode_reg};
            OFF_STATUS:      read_mux = {{(BYTE_W-1){1'b0}}, mult_done_reg};
            default:         read_mux = '0;
        endcase
    end

    always_comb
    begin
        dividend_next   = dividend_reg;
        multiplier_next = multiplier_reg;
        divisor_next    = divisor_reg;
        result_next     = result_reg;
        remainder_next  = remainder_reg;
        sign_mode_next  = sign_mode_reg;
        mult_done_next  = mult_done_reg;
        rdata_next      = rdata_reg;
        quo_next        = quo_reg;
        part_next       = part_reg;
        mag_b_next      = mag_b_reg;
        neg_q_next      = neg_q_reg;
        neg_r_next      = neg_r_reg;
        count_next      = count_reg;

        if (ctrl.access)
        begin
            rdata_next = (in_cmd == CMD_WRITE) ? '0 : read_mux;
            if (in_cmd == CMD_WRITE)
            begin
                unique case (in_offset)
                    OFF_DIVIDEND_B0: dividend_next[7:0]    = in_wdata;
                    OFF_DIVIDEND_B1: dividend_next[15:8]   = in_wdata;
                    OFF_DIVIDEND_B2: dividend_next[23:16]  = in_wdata;
                    OFF_DIVIDEND_B3: dividend_next[31:24]  = in_wdata;
                    OFF_MULT_LO:     multiplier_next[7:0]  = in_wdata;
                    OFF_MULT_HI:     multiplier_next[15:8] = in_wdata;
                    OFF_DIVISOR_LO:  divisor_next[7:0]     = in_wdata;
                    OFF_DIVISOR_HI:  divisor_next[15:8]    = in_wdata;
                    OFF_SIGN_MODE:   sign_mode_next        = in_wdata[0];
                    default:         ;   // read-only registers ignore writes
                endcase
            end
        end

        if (ctrl.mul_exec)
        begin
            result_next    = product[DIVIDEND_W-1:0];
            mult_done_next = 1'b1;
        end

        if (ctrl.div_init)
        begin
            if (status.div_zero)
            begin
                result_next    = '0;
                remainder_next = dividend_reg[HALF_W-1:0];
            end
            else
            begin
                quo_next   = neg_a ? (DIVIDEND_W'(0) - dividend_reg) : dividend_reg;
                mag_b_next = neg_b ? (HALF_W'(0) - divisor_reg) : divisor_reg;
                part_next  = '0;
                count_next = '0;
                neg_q_next = neg_a ^ neg_b;
                neg_r_next = neg_a;
            end
        end

        if (ctrl.div_step)
        begin
            // shift in the next dividend bit, subtract if it fits
            if (!diff[HALF_W+1])
                part_next = diff[HALF_W:0];
            else
                part_next = part_shift;
            quo_next   = {quo_reg[DIVIDEND_W-2:0], ~diff[HALF_W+1]};
            count_next = count_reg + COUNT_W'(1);
        end

        if (ctrl.div_fix)
        begin
            result_next    = neg_q_reg ? (DIVIDEND_W'(0) - quo_reg) : quo_reg;
            remainder_next = neg_r_reg ? (HALF_W'(0) - part_reg[HALF_W-1:0])
                                       : part_reg[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg   <= '0;
            multiplier_reg <= '0;
            divisor_reg    <= '0;
            result_reg     <= '0;
            remainder_reg  <= '0;
            sign_mode_reg  <= 1'b0;
            mult_done_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            dividend_reg   <= dividend_next;
            multiplier_reg <= multiplier_next;
            divisor_reg    <= divisor_next;
            result_reg     <= result_next;
            remainder_reg  <= remainder_next;
            sign_mode_reg  <= sign_mode_next;
            mult_done_reg  <= mult_done_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        quo_reg   <= quo_next;
        part_reg  <= part_next;
        mag_b_reg <= mag_b_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

endmodule
`default_nettype wire

// ===== rtl/register_mapped_mul_div_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register-mapped multiply/divide unit
// Sixteen byte registers on a streaming access port with a 16x16 multiplier
// and a 32/16 divider, signed or unsigned.
// ----------------------------------------------------------------------------
// Each input item is one bus access (read or write of one register byte) and
// yields exactly one output item: the byte read, or zero for a write. The unit
// works on one item at a time. A read or plain write accepted at one edge has
// its reply on the output in the next cycle. Writing the multiplier high byte
// adds a multiply state that registers the 17x17 product. Writing the divisor
// high byte runs the divider: a setup state, then 32 steps of the restoring
// divider (one quotient bit per cycle) and a sign-correction state; a divide
// by zero finishes in the setup state. The next item is taken once the reply
// has been accepted downstream.
// ----------------------------------------------------------------------------
module register_mapped_mul_div_unit_core
    import mdu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // access items in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [3:0] reg_offset, [11:4] write_data, rest 0
    input  wire logic        s_axis_tuser,   // [0] cmd: 0 read, 1 write
    // reply items out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [7:0] read_data
);

    mdu_cmd_t    ctrl;
    mdu_status_t status;

    // sequence access, multiply or divide, then hold the reply until taken
    mdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // register file and arithmetic; the reply byte is registered inside
    mdu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_cmd    (s_axis_tuser),
        .in_offset (s_axis_tdata[3:0]),
        .in_wdata  (s_axis_tdata[11:4]),
        .status    (status),
        .read_data (m_axis_tdata)
    );

endmodule
`default_nettype wire
